// ===== rtl/spc_pkg.sv =====
`default_nettype none

package spc_pkg;

   // Field widths of the three channels
   localparam int SENSE_W    = 10;
   localparam int ANGLE_W    = 11;   // internal angle, -800..998 tenths of a degree
   localparam int QUO_W      = ANGLE_W - 1;
   localparam int FILT_W     = 12;
   localparam int TARGET_W   = 12;
   localparam int ERR_W      = 13;
   localparam int DIFF_W     = ERR_W + 1;
   localparam int GAIN_W     = 32;
   localparam int SUM_W      = 32;
   localparam int DRIVE_W    = 18;
   localparam int DUTY_W     = 14;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;

   // Current sense: volts*10 = raw*3315/102400, limit trips above 40
   localparam logic [22:0] SENSE_SCALE    = 23'd3315;
   localparam logic [22:0] OC_PRODUCT_MIN = 23'd4198400;

   // Position: angle = trunc((225*(raw-512) + 12800) / 128)
   localparam logic signed [10:0] POS_CENTRE = 11'sd512;
   localparam logic signed [17:0] POS_SCALE  = 18'sd225;
   localparam logic signed [17:0] POS_OFFSET = 18'sd12800;
   localparam logic signed [17:0] POS_ROUND  = 18'sd127;

   // Error deadband of one degree
   localparam logic signed [ERR_W-1:0] DEADBAND = 13'sd10;

   // Drive limits, hundredths of a percent
   localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT = 18'sd100000;
   localparam logic signed [DRIVE_W-1:0] DEADZONE    = 18'sd1000;
   localparam logic [DUTY_W-1:0]         DUTY_MAX    = 14'd9000;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TARGET = 3'd0,
      CSR_PROP   = 3'd1,
      CSR_INTEG  = 3'd2,
      CSR_DERIV  = 3'd3,
      CSR_BIAS   = 3'd4
   } csr_index_type;

   // Load strobes for the averaging stages
   typedef struct packed {
      logic shift_in;   // new angle enters the ring, total register takes the sum
      logic load_quo;   // quotient register takes the scaled total
   } avg_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/spc_ifs.sv =====
`default_nettype none

interface spc_req_if;
   import spc_pkg::*;
   logic               valid;
   logic               ready;
   logic [SENSE_W-1:0] left_sense;
   logic [SENSE_W-1:0] right_sense;
   logic [SENSE_W-1:0] position_raw;
   modport source (output valid, left_sense, right_sense, position_raw, input ready);
   modport sink   (input valid, left_sense, right_sense, position_raw, output ready);
endinterface

interface spc_rsp_if;
   import spc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [DUTY_W-1:0]         left_duty;
   logic [DUTY_W-1:0]         right_duty;
   logic signed [FILT_W-1:0]  angle_filtered;
   logic signed [ERR_W-1:0]   angle_error;
   logic                      over_current;
   logic signed [DRIVE_W-1:0] drive_value;
   modport source (output valid, left_duty, right_duty, angle_filtered, angle_error,
                   over_current, drive_value, input ready);
   modport sink   (input valid, left_duty, right_duty, angle_filtered, angle_error,
                   over_current, drive_value, output ready);
endinterface

interface spc_csr_if;
   import spc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/spc_avg.sv =====
`default_nettype none

module spc_avg #(
   parameter int AVERAGE_DEPTH = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  spc_pkg::avg_ctl_type                ctl,
   input  logic signed [spc_pkg::ANGLE_W-1:0]  angle,
   output logic [spc_pkg::QUO_W-1:0]           quo,
   output logic                                quo_neg
);
   import spc_pkg::*;

   localparam int DEPTH_LOG = $clog2(AVERAGE_DEPTH);
   localparam int TOT_W     = ANGLE_W + DEPTH_LOG;
   localparam int MAG_W     = TOT_W - 1;
   localparam int SHIFT     = MAG_W + DEPTH_LOG;
   localparam int RECIP_W   = MAG_W + 1;
   localparam int PROD_W    = MAG_W + RECIP_W;
   // Rounded-up reciprocal: exact truncating quotient for any magnitude below 2**MAG_W
   localparam longint unsigned RECIP_FULL =
      ((64'd1 << SHIFT) + AVERAGE_DEPTH - 1) / AVERAGE_DEPTH;
   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_FULL);

   logic signed [ANGLE_W-1:0] ring_ff [AVERAGE_DEPTH];
   logic signed [TOT_W-1:0]   total_ff;
   logic signed [TOT_W-1:0]   total_in;
   logic signed [TOT_W-1:0]   total_abs;
   logic [MAG_W-1:0]          mag;
   logic [PROD_W-1:0]         prod;
   logic [QUO_W-1:0]          quo_ff;
   logic                      quo_neg_ff;

   // Running sum: add the newcomer, drop the oldest entry
   assign total_in = total_ff + angle - ring_ff[AVERAGE_DEPTH-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         for (int i = 0; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= '0;
         end
      end else if (ctl.shift_in) begin
         total_ff   <= total_in;
         ring_ff[0] <= angle;
         for (int i = 1; i < AVERAGE_DEPTH; i++) begin
            ring_ff[i] <= ring_ff[i-1];
         end
      end
   end

   // Divide the magnitude by the depth through the reciprocal
   assign total_abs = total_ff[TOT_W-1] ? -total_ff : total_ff;
   assign mag       = total_abs[MAG_W-1:0];
   assign prod      = PROD_W'(mag) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (ctl.load_quo) begin
         quo_ff     <= prod[SHIFT +: QUO_W];
         quo_neg_ff <= total_ff[TOT_W-1];
      end
   end

   assign quo     = quo_ff;
   assign quo_neg = quo_neg_ff;

endmodule

`default_nettype wire

// ===== rtl/spc_bridge.sv =====
`default_nettype none

module spc_bridge (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                commit,
   input  logic signed [spc_pkg::DRIVE_W-1:0]  pid,
   input  logic                                over_current,
   output logic signed [spc_pkg::DRIVE_W-1:0]  cmd,
   output logic [spc_pkg::DUTY_W-1:0]          left_duty,
   output logic [spc_pkg::DUTY_W-1:0]          right_duty
);
   import spc_pkg::*;

   typedef enum logic [1:0] {
      SIGN_ZERO,
      SIGN_POS,
      SIGN_NEG
   } sign_type;

   logic signed [DRIVE_W-1:0] pid_ff;
   sign_type                  last_sign_ff;
   sign_type                  sign_in;
   logic signed [DRIVE_W-1:0] cmd_abs;
   logic [DUTY_W-1:0]         duty;
   logic                      reversal;

   // Over-current holds the last drive direction at the deadzone edge
   always_comb begin
      if (over_current) begin
         cmd = pid_ff[DRIVE_W-1] ? -DEADZONE : DEADZONE;
      end else begin
         cmd = pid;
      end
   end

   always_comb begin
      if (cmd == '0) begin
         sign_in = SIGN_ZERO;
      end else if (cmd[DRIVE_W-1]) begin
         sign_in = SIGN_NEG;
      end else begin
         sign_in = SIGN_POS;
      end
   end

   assign reversal = ((sign_in == SIGN_NEG) && (last_sign_ff == SIGN_POS)) ||
                     ((sign_in == SIGN_POS) && (last_sign_ff == SIGN_NEG));

   // Clamp the magnitude to the duty ceiling
   assign cmd_abs = cmd[DRIVE_W-1] ? -cmd : cmd;
   assign duty    = (cmd_abs > $signed({4'b0, DUTY_MAX})) ? DUTY_MAX : cmd_abs[DUTY_W-1:0];

   // Drive one side only, outside the deadzone, never on a reversal tick
   assign left_duty  = (!reversal && (cmd < -DEADZONE)) ? duty : '0;
   assign right_duty = (!reversal && (cmd > DEADZONE))  ? duty : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         pid_ff       <= '0;
         last_sign_ff <= SIGN_ZERO;
      end else if (commit) begin
         last_sign_ff <= sign_in;
         if (!over_current) begin
            pid_ff <= pid;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/servo_pid_hbridge_controller.sv =====
`default_nettype none

// Position servo with moving-average filter, PID and H-bridge drive. Each transaction on req_bus
// carries one control tick (two current samples, one position sample) and yields exactly one
// transaction on rsp_bus, presented from the output register and held there while
// rsp_bus stalls. The datapath is a ten-stage pipeline: position scaling,
// running sum over AVERAGE_DEPTH angles, division by reciprocal multiply, deadbanded error,
// integral update, three gain multipliers, two accumulate stages, drive saturation, then the
// bridge stage into the output register. It takes one transaction every cycle while stage 0 can
// advance; a stalled result stops only the unbroken run of full stages behind it. Configuration
// writes on csr_bus are always accepted and should be made while no tick is in flight.
module servo_pid_hbridge_controller #(
   parameter int AVERAGE_DEPTH = 8
) (
   input  logic           clock,
   input  logic           reset,
   spc_req_if.sink        req_bus,
   spc_rsp_if.source      rsp_bus,
   spc_csr_if.sink        csr_bus
);
   import spc_pkg::*;

   localparam int NS = 10;

   // Configuration registers
   logic signed [TARGET_W-1:0] target_ff;
   logic signed [GAIN_W-1:0]   gain_prop_ff;
   logic signed [GAIN_W-1:0]   gain_integ_ff;
   logic signed [GAIN_W-1:0]   gain_deriv_ff;
   logic signed [DRIVE_W-1:0]  bias_ff;

   // Pipeline control
   logic [NS-1:0] valid_ff;
   logic [NS-1:0] valid_in;
   logic [NS-1:0] rdy;
   logic [NS-1:0] take;

   // Stage payloads
   logic [SENSE_W-1:0]        left0_ff, right0_ff, pos0_ff;
   logic                      oc1_ff, oc2_ff;
   logic signed [ERR_W-1:0]   err3_ff, err4_ff, err5_ff, err6_ff, err7_ff, err8_ff;
   logic signed [ANGLE_W-1:0] filt3_ff, filt4_ff, filt5_ff, filt6_ff, filt7_ff, filt8_ff;
   logic                      oc3_ff, oc4_ff, oc5_ff, oc6_ff, oc7_ff, oc8_ff;
   logic signed [SUM_W-1:0]   sum4_ff;
   logic signed [DIFF_W-1:0]  diff4_ff;
   logic signed [44:0]        pp5_ff;
   logic signed [63:0]        pi5_ff, pi6_ff;
   logic signed [45:0]        pd5_ff;
   logic signed [46:0]        pd6_ff;
   logic signed [63:0]        acc7_ff;
   logic signed [DRIVE_W-1:0] pid8_ff;

   // Integral state
   logic signed [SUM_W-1:0] error_sum_ff;
   logic signed [ERR_W-1:0] prev_err_ff;

   // Output register
   logic [DUTY_W-1:0]         left_duty_ff, right_duty_ff;
   logic signed [FILT_W-1:0]  filt_out_ff;
   logic signed [ERR_W-1:0]   err_out_ff;
   logic                      oc_out_ff;
   logic signed [DRIVE_W-1:0] drive_out_ff;

   // Combinational values between stages
   logic signed [ANGLE_W-1:0] centred;
   logic signed [17:0]        pos_num;
   logic signed [17:0]        pos_adj;
   logic signed [ANGLE_W-1:0] angle_in;
   logic [22:0]               amp_left, amp_right;
   logic                      oc_in;
   avg_ctl_type               avg_ctl;
   logic [QUO_W-1:0]          quo;
   logic                      quo_neg;
   logic signed [ANGLE_W-1:0] quo_mag;
   logic signed [ANGLE_W-1:0] filt_in;
   logic signed [ERR_W-1:0]   err_raw;
   logic signed [ERR_W-1:0]   err_in;
   logic signed [SUM_W:0]     sum_wide;
   logic signed [SUM_W-1:0]   sum_in;
   logic signed [DIFF_W-1:0]  diff_in;
   logic signed [44:0]        pp_in;
   logic signed [63:0]        pi_in;
   logic signed [45:0]        pd_in;
   logic signed [46:0]        pd6_in;
   logic signed [63:0]        acc_in;
   logic signed [48:0]        biased;
   logic signed [DRIVE_W-1:0] pid_in;
   logic signed [DRIVE_W-1:0] cmd;
   logic [DUTY_W-1:0]         left_duty, right_duty;

   // Configuration writes
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff     <= '0;
         gain_prop_ff  <= '0;
         gain_integ_ff <= '0;
         gain_deriv_ff <= '0;
         bias_ff       <= '0;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_TARGET: target_ff     <= csr_bus.data[TARGET_W-1:0];
            CSR_PROP:   gain_prop_ff  <= csr_bus.data;
            CSR_INTEG:  gain_integ_ff <= csr_bus.data;
            CSR_DERIV:  gain_deriv_ff <= csr_bus.data;
            CSR_BIAS:   bias_ff       <= csr_bus.data[DRIVE_W-1:0];
            default:    ;
         endcase
      end
   end

   // Advance each stage when the one ahead is empty or moving
   always_comb begin
      rdy[NS-1] = !valid_ff[NS-1] || rsp_bus.ready;
      for (int k = NS - 2; k >= 0; k--) begin
         rdy[k] = !valid_ff[k] || rdy[k+1];
      end
      take[0] = req_bus.valid && rdy[0];
      for (int k = 1; k < NS; k++) begin
         take[k] = valid_ff[k-1] && rdy[k];
      end
      for (int k = 0; k < NS - 1; k++) begin
         valid_in[k] = take[k] || (valid_ff[k] && !rdy[k+1]);
      end
      valid_in[NS-1] = take[NS-1] || (valid_ff[NS-1] && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_bus.ready = rdy[0];

   // Stage 0: scale position to tenths of a degree, check current limit
   assign centred  = $signed({1'b0, pos0_ff}) - POS_CENTRE;
   assign pos_num  = centred * POS_SCALE + POS_OFFSET;
   assign pos_adj  = pos_num[17] ? pos_num + POS_ROUND : pos_num;
   assign angle_in = pos_adj[17:7];
   assign amp_left  = 23'(left0_ff) * SENSE_SCALE;
   assign amp_right = 23'(right0_ff) * SENSE_SCALE;
   assign oc_in     = (amp_left >= OC_PRODUCT_MIN) || (amp_right >= OC_PRODUCT_MIN);

   // Stages 1 and 2: running sum and division
   assign avg_ctl.shift_in = take[1];
   assign avg_ctl.load_quo = take[2];

   spc_avg #(
      .AVERAGE_DEPTH (AVERAGE_DEPTH)
   ) u_avg (
      .clock   (clock),
      .reset   (reset),
      .ctl     (avg_ctl),
      .angle   (angle_in),
      .quo     (quo),
      .quo_neg (quo_neg)
   );

   // Stage 2: restore sign, form deadbanded error
   assign quo_mag = $signed({1'b0, quo});
   assign filt_in = quo_neg ? -quo_mag : quo_mag;
   assign err_raw = target_ff - filt_in;
   assign err_in  = ((err_raw < DEADBAND) && (err_raw > -DEADBAND)) ? '0 : err_raw;

   // Stage 3: saturating integral and error difference
   assign sum_wide = error_sum_ff + err3_ff;
   always_comb begin
      if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
         sum_in = sum_wide[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
      end else begin
         sum_in = sum_wide[SUM_W-1:0];
      end
   end
   assign diff_in = err3_ff - prev_err_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff <= '0;
         prev_err_ff  <= '0;
      end else if (take[4] && !oc3_ff) begin
         error_sum_ff <= sum_in;
         prev_err_ff  <= err3_ff;
      end
   end

   // Stage 4: gain products; stages 5 and 6: accumulate
   assign pp_in  = gain_prop_ff * err4_ff;
   assign pi_in  = gain_integ_ff * sum4_ff;
   assign pd_in  = gain_deriv_ff * diff4_ff;
   assign pd6_in = pp5_ff + pd5_ff;
   assign acc_in = pi6_ff + pd6_ff;

   // Stage 7: drop the fraction by floor, add bias, saturate
   assign biased = $signed(acc7_ff[63:16]) + bias_ff;
   always_comb begin
      if (biased > DRIVE_LIMIT) begin
         pid_in = DRIVE_LIMIT;
      end else if (biased < -DRIVE_LIMIT) begin
         pid_in = -DRIVE_LIMIT;
      end else begin
         pid_in = biased[DRIVE_W-1:0];
      end
   end

   // Stage 8: bridge logic
   spc_bridge u_bridge (
      .clock        (clock),
      .reset        (reset),
      .commit       (take[9]),
      .pid          (pid8_ff),
      .over_current (oc8_ff),
      .cmd          (cmd),
      .left_duty    (left_duty),
      .right_duty   (right_duty)
   );

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (take[0]) begin
         left0_ff  <= req_bus.left_sense;
         right0_ff <= req_bus.right_sense;
         pos0_ff   <= req_bus.position_raw;
      end
      if (take[1]) begin
         oc1_ff <= oc_in;
      end
      if (take[2]) begin
         oc2_ff <= oc1_ff;
      end
      if (take[3]) begin
         err3_ff  <= err_in;
         filt3_ff <= filt_in;
         oc3_ff   <= oc2_ff;
      end
      if (take[4]) begin
         err4_ff  <= err3_ff;
         sum4_ff  <= sum_in;
         diff4_ff <= diff_in;
         filt4_ff <= filt3_ff;
         oc4_ff   <= oc3_ff;
      end
      if (take[5]) begin
         pp5_ff   <= pp_in;
         pi5_ff   <= pi_in;
         pd5_ff   <= pd_in;
         err5_ff  <= err4_ff;
         filt5_ff <= filt4_ff;
         oc5_ff   <= oc4_ff;
      end
      if (take[6]) begin
         pd6_ff   <= pd6_in;
         pi6_ff   <= pi5_ff;
         err6_ff  <= err5_ff;
         filt6_ff <= filt5_ff;
         oc6_ff   <= oc5_ff;
      end
      if (take[7]) begin
         acc7_ff  <= acc_in;
         err7_ff  <= err6_ff;
         filt7_ff <= filt6_ff;
         oc7_ff   <= oc6_ff;
      end
      if (take[8]) begin
         pid8_ff  <= pid_in;
         err8_ff  <= err7_ff;
         filt8_ff <= filt7_ff;
         oc8_ff   <= oc7_ff;
      end
      if (take[9]) begin
         left_duty_ff  <= left_duty;
         right_duty_ff <= right_duty;
         filt_out_ff   <= FILT_W'(filt8_ff);
         err_out_ff    <= err8_ff;
         oc_out_ff     <= oc8_ff;
         drive_out_ff  <= cmd;
      end
   end

   // Result transaction
   assign rsp_bus.valid          = valid_ff[NS-1];
   assign rsp_bus.left_duty      = left_duty_ff;
   assign rsp_bus.right_duty     = right_duty_ff;
   assign rsp_bus.angle_filtered = filt_out_ff;
   assign rsp_bus.angle_error    = err_out_ff;
   assign rsp_bus.over_current   = oc_out_ff;
   assign rsp_bus.drive_value    = drive_out_ff;

endmodule

`default_nettype wire
